>>> rtl/ast_pkg.sv
// Shared types and constants for the assembly source tokenizer.
// Holds the payload structs, token kind codes and the token group type.
// No dependencies.
package ast_pkg;

  localparam int OFFSET_BITS = 20;
  localparam int KIND_BITS   = 5;
  localparam int MAX_TOKENS  = 3;

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [KIND_BITS-1:0]   kind_t;

  // Token kinds
  localparam kind_t KIND_NUMBER = 5'd0;
  localparam kind_t KIND_IDENT  = 5'd1;
  localparam kind_t KIND_LPAREN = 5'd2;
  localparam kind_t KIND_RPAREN = 5'd3;
  localparam kind_t KIND_PLUS   = 5'd4;
  localparam kind_t KIND_MINUS  = 5'd5;
  localparam kind_t KIND_AT     = 5'd6;
  localparam kind_t KIND_BANG   = 5'd7;
  localparam kind_t KIND_AMP    = 5'd8;
  localparam kind_t KIND_PIPE   = 5'd9;
  localparam kind_t KIND_EQ     = 5'd10;
  localparam kind_t KIND_SEMI   = 5'd11;
  localparam kind_t KIND_JGT    = 5'd12;
  localparam kind_t KIND_JLT    = 5'd13;
  localparam kind_t KIND_JGE    = 5'd14;
  localparam kind_t KIND_JLE    = 5'd15;
  localparam kind_t KIND_JEQ    = 5'd16;
  localparam kind_t KIND_JNE    = 5'd17;
  localparam kind_t KIND_JMP    = 5'd18;
  localparam kind_t KIND_DST_M   = 5'd19;
  localparam kind_t KIND_DST_D   = 5'd20;
  localparam kind_t KIND_DST_DM  = 5'd21;
  localparam kind_t KIND_DST_A   = 5'd22;
  localparam kind_t KIND_DST_AM  = 5'd23;
  localparam kind_t KIND_DST_AD  = 5'd24;
  localparam kind_t KIND_DST_ADM = 5'd25;
  localparam kind_t KIND_EOF    = 5'd26;
  localparam kind_t KIND_ERROR  = 5'd27;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_source;
  } ast_in_t;

  typedef struct packed {
    kind_t   token_kind;
    offset_t token_start;
    offset_t token_end;
    logic    run_last;
  } ast_out_t;

  // One token as produced by the scanner.
  typedef struct packed {
    kind_t   kind;
    offset_t start_ofs;
    offset_t end_ofs;
  } ast_tok_t;

  // All tokens caused by one source byte; cnt is 1 to MAX_TOKENS.
  typedef struct packed {
    ast_tok_t [MAX_TOKENS-1:0] tok;
    logic [1:0]                cnt;
  } ast_grp_t;

endpackage

>>> rtl/ast_front.sv
// Scanner front end: accepts source bytes and builds the token group of each byte.
// Depends on ast_pkg.
module ast_front import ast_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  ast_in_t  in_data,
  output logic     in_ready,
  input  logic     q_full,
  output logic     push_valid,
  output ast_grp_t push_grp
);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_NUMBER = 2'd1,
    MODE_IDENT  = 2'd2,
    MODE_SKIP   = 2'd3
  } mode_t;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LF    = 8'h0A;

  mode_t       mode_r, mode_nxt;
  offset_t     start_r, start_nxt;
  offset_t     offset_r, offset_nxt;
  logic [23:0] prefix_r, prefix_nxt;
  logic [2:0]  len_r, len_nxt;

  ast_tok_t [MAX_TOKENS-1:0] tok_c;
  logic [1:0]                cnt_c;
  logic                      classify_c;
  offset_t                   p_c, q_c;
  logic [7:0]                c_c;
  logic                      accept;

  function automatic logic is_numeral(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return (c == "_") || (c == ".") || (c == "$") ||
           ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || (c == 8'h0A) || (c == 8'h0D) || (c == 8'h09) ||
           (c == 8'h08) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h00);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == "(") || (c == ")") || (c == "+") || (c == "-") || (c == "@") ||
           (c == "!") || (c == "&") || (c == "|") || (c == "=") || (c == ";");
  endfunction

  function automatic kind_t punct_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "@":     k = KIND_AT;
      "!":     k = KIND_BANG;
      "&":     k = KIND_AMP;
      "|":     k = KIND_PIPE;
      "=":     k = KIND_EQ;
      default: k = KIND_SEMI;
    endcase
    return k;
  endfunction

  // Identifiers longer than three characters fall to the default arm.
  function automatic kind_t kw_kind(input logic [2:0] len, input logic [23:0] prefix);
    kind_t k;
    unique case ({len, prefix})
      {3'd3, "JGT"}:        k = KIND_JGT;
      {3'd3, "JLT"}:        k = KIND_JLT;
      {3'd3, "JGE"}:        k = KIND_JGE;
      {3'd3, "JLE"}:        k = KIND_JLE;
      {3'd3, "JEQ"}:        k = KIND_JEQ;
      {3'd3, "JNE"}:        k = KIND_JNE;
      {3'd3, "JMP"}:        k = KIND_JMP;
      {3'd1, 16'h0, "M"}:   k = KIND_DST_M;
      {3'd1, 16'h0, "D"}:   k = KIND_DST_D;
      {3'd2, 8'h0, "DM"}:   k = KIND_DST_DM;
      {3'd1, 16'h0, "A"}:   k = KIND_DST_A;
      {3'd2, 8'h0, "AM"}:   k = KIND_DST_AM;
      {3'd2, 8'h0, "AD"}:   k = KIND_DST_AD;
      {3'd3, "ADM"}:        k = KIND_DST_ADM;
      default:              k = KIND_IDENT;
    endcase
    return k;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign c_c      = in_data.source_byte;
  assign p_c      = offset_r;
  assign q_c      = (offset_r == '1) ? offset_r : offset_r + 1'b1;

  always_comb begin
    mode_nxt   = mode_r;
    start_nxt  = start_r;
    prefix_nxt = prefix_r;
    len_nxt    = len_r;
    offset_nxt = q_c;
    tok_c      = '0;
    cnt_c      = 2'd0;
    classify_c = 1'b0;

    // Close or extend the pending lexeme.
    unique case (mode_r)
      MODE_NUMBER: begin
        if (!is_numeral(c_c)) begin
          tok_c[cnt_c] = '{kind: KIND_NUMBER, start_ofs: start_r, end_ofs: p_c};
          cnt_c        = cnt_c + 2'd1;
          mode_nxt     = MODE_IDLE;
          classify_c   = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (is_numeral(c_c) || is_word_char(c_c)) begin
          if (len_r < 3'd3) prefix_nxt = {prefix_r[15:0], c_c};
          if (len_r < 3'd4) len_nxt = len_r + 3'd1;
        end else begin
          tok_c[cnt_c] = '{kind: kw_kind(len_r, prefix_r), start_ofs: start_r, end_ofs: p_c};
          cnt_c        = cnt_c + 2'd1;
          mode_nxt     = MODE_IDLE;
          classify_c   = 1'b1;
        end
      end
      MODE_SKIP: begin
        if (c_c == CH_LF) mode_nxt = MODE_IDLE;
      end
      default: begin
        classify_c = 1'b1;
      end
    endcase

    // Classify a byte seen with no lexeme pending.
    if (classify_c) begin
      if (is_space(c_c)) begin
        mode_nxt = MODE_IDLE;
      end else if (c_c == CH_SLASH) begin
        mode_nxt = MODE_SKIP;
      end else if (is_punct(c_c)) begin
        tok_c[cnt_c] = '{kind: punct_kind(c_c), start_ofs: p_c, end_ofs: q_c};
        cnt_c        = cnt_c + 2'd1;
      end else if (is_numeral(c_c)) begin
        mode_nxt  = MODE_NUMBER;
        start_nxt = p_c;
      end else if (is_word_char(c_c)) begin
        mode_nxt   = MODE_IDENT;
        start_nxt  = p_c;
        prefix_nxt = {16'h0, c_c};
        len_nxt    = 3'd1;
      end else begin
        tok_c[cnt_c] = '{kind: KIND_ERROR, start_ofs: p_c, end_ofs: q_c};
        cnt_c        = cnt_c + 2'd1;
        mode_nxt     = MODE_SKIP;
      end
    end

    // The final byte closes what is pending, adds end of file and rewinds.
    if (in_data.end_of_source) begin
      if (mode_nxt == MODE_NUMBER) begin
        tok_c[cnt_c] = '{kind: KIND_NUMBER, start_ofs: start_nxt, end_ofs: q_c};
        cnt_c        = cnt_c + 2'd1;
      end else if (mode_nxt == MODE_IDENT) begin
        tok_c[cnt_c] = '{kind: kw_kind(len_nxt, prefix_nxt), start_ofs: start_nxt,
                         end_ofs: q_c};
        cnt_c        = cnt_c + 2'd1;
      end
      tok_c[cnt_c] = '{kind: KIND_EOF, start_ofs: q_c, end_ofs: q_c};
      cnt_c        = cnt_c + 2'd1;
      mode_nxt     = MODE_IDLE;
      start_nxt    = '0;
      offset_nxt   = '0;
      prefix_nxt   = '0;
      len_nxt      = 3'd0;
    end
  end

  assign push_valid   = accept && (cnt_c != 2'd0);
  assign push_grp.tok = tok_c;
  assign push_grp.cnt = cnt_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      start_r  <= '0;
      offset_r <= '0;
      prefix_r <= '0;
      len_r    <= 3'd0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      start_r  <= start_nxt;
      offset_r <= offset_nxt;
      prefix_r <= prefix_nxt;
      len_r    <= len_nxt;
    end
  end

endmodule

>>> rtl/ast_queue.sv
// Token group queue between the scanner front end and the output back end.
// Depends on ast_pkg.
module ast_queue import ast_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ast_grp_t push_grp,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output ast_grp_t head_grp
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ast_grp_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_grp  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_grp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

>>> rtl/ast_back.sv
// Output back end: unpacks token groups and drives one token per transfer.
// Depends on ast_pkg.
module ast_back import ast_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  ast_grp_t q_grp,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output ast_out_t out_data
);

  ast_grp_t   grp_r;
  logic       grp_valid_r;
  logic [1:0] idx_r;
  logic       out_valid_r;
  ast_out_t   out_data_r;
  logic       load, last;

  assign load  = grp_valid_r && (!out_valid_r || out_ready);
  assign last  = (idx_r == grp_r.cnt - 2'd1);
  assign q_pop = q_valid && (!grp_valid_r || (load && last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_valid_r <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        grp_valid_r <= 1'b1;
        idx_r       <= 2'd0;
      end else if (load && last) begin
        grp_valid_r <= 1'b0;
      end else if (load) begin
        idx_r <= idx_r + 2'd1;
      end
      if (load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) grp_r <= q_grp;
    if (load) begin
      out_data_r.token_kind  <= grp_r.tok[idx_r].kind;
      out_data_r.token_start <= grp_r.tok[idx_r].start_ofs;
      out_data_r.token_end   <= grp_r.tok[idx_r].end_ofs;
      out_data_r.run_last    <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/assembly_source_tokenizer.sv
// Top level of the assembly source tokenizer: front end, group queue, back end.
// Depends on ast_pkg, ast_front, ast_queue and ast_back.
//
// Channel  Dir  Handshake             Payload
// in       in   in_valid / in_ready   ast_in_t  in_data  (one source byte)
// out      out  out_valid / out_ready ast_out_t out_data (one token)
//
// One source byte is taken per cycle while the queue is not full. Each byte causes
// zero to three tokens; any it causes go as one group into the queue in the same cycle.
// The back end drives one token per cycle from its output register while out_ready
// is high, so the byte rate stays at one per cycle while bytes average at most one
// token; the single output register sets that limit.
// With the back end idle, a byte's group is written into the queue at its transfer,
// popped into the group register, and its token loaded into the output register.
// Reset is synchronous and active low; it clears the scanner state, the queue
// pointers and the valid flags.
// in_ready drops only while the queue is full, which happens when out_ready
// stalls or bursts of tokens outrun the output register.
module assembly_source_tokenizer import ast_pkg::*; #(
  parameter int QUEUE_DEPTH = 4  // token groups held between the halves, 2 to 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ast_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ast_out_t out_data
);

  logic     q_full, push_valid, q_not_empty, q_pop;
  ast_grp_t push_grp, head_grp;

  // The front end scans bytes and builds a group for every byte that yields tokens.
  ast_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_ready   (in_ready),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_grp   (push_grp)
  );

  // The queue lets the scanner keep going while the output side is stalled.
  ast_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_grp  (push_grp),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_grp  (head_grp)
  );

  // The back end serializes each group and marks its final token with run_last.
  ast_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_grp     (head_grp),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> rtl/ast_checker.sv
// Port-level checks for the assembly source tokenizer, bound to its top level.
// Depends on ast_pkg and assembly_source_tokenizer.
module ast_checker import ast_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input ast_out_t out_data
);

  // A stalled token holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("token changed while stalled");

  // Reset empties the output register.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("token shown right after reset");

  // No token ends before it starts.
  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.token_end >= out_data.token_start)
    else $error("token end before start");

  // End of file is an empty span and closes its run.
  a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.token_kind == KIND_EOF |->
      out_data.token_start == out_data.token_end && out_data.run_last)
    else $error("malformed end-of-file token");

  // Punctuation and error tokens cover one byte unless the offset saturated.
  a_single_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.token_kind >= KIND_LPAREN && out_data.token_kind <= KIND_SEMI) ||
                  out_data.token_kind == KIND_ERROR) |->
      out_data.token_end == out_data.token_start + 1'b1 ||
      (out_data.token_start == '1 && out_data.token_end == out_data.token_start))
    else $error("single-byte token has wrong span");

endmodule

bind assembly_source_tokenizer ast_checker u_ast_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> verif/assembly_source_tokenizer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for assembly_source_tokenizer: streams source text, predicts tokens.
// Depends on ast_pkg and the assembly_source_tokenizer RTL; no other files are read.
module assembly_source_tokenizer_tb;
  import ast_pkg::*;

  // A run that sees no transfer on either channel for this many cycles has hung.
  // The slowest correct stretch is the long output hold plus a few idle draws,
  // so this limit leaves a wide margin.
  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 80;
  localparam int TARGET_BYTES = 280;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SLASH   = "/";
  localparam logic [7:0] CH_NUL     = 8'h00;

  // Scanner modes of the prediction.
  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_NUMBER,
    SCAN_IDENT,
    SCAN_SKIP_LINE
  } scan_mode_e;

  // The scoreboard keeps its own copy of the scanner state. Every accepted
  // source byte is run through it, and the tokens it yields are queued in
  // order; every token that leaves the block is matched against the oldest.
  class lexer_checker;
    ast_out_t   expected_tokens[$];
    ast_out_t   step_tokens[$];
    scan_mode_e mode;
    offset_t    lexeme_start;
    offset_t    next_offset;
    logic [23:0] lexeme_prefix;
    logic [2:0] lexeme_length;
    int         mismatches;
    int         tokens_checked;
    int         bytes_noted;

    function new();
      clear_state();
      mismatches     = 0;
      tokens_checked = 0;
      bytes_noted    = 0;
    endfunction

    function void clear_state();
      mode          = SCAN_IDLE;
      lexeme_start  = '0;
      next_offset   = '0;
      lexeme_prefix = '0;
      lexeme_length = '0;
    endfunction

    function bit is_numeral(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_word_char(logic [7:0] c);
      return c == "_" || c == "." || c == "$" || (c >= "a" && c <= "z") ||
             (c >= "A" && c <= "Z");
    endfunction

    function bit is_blank(logic [7:0] c);
      return c inside {" ", CH_NEWLINE, 8'h0D, 8'h09, 8'h08, 8'h0B, 8'h0C, CH_NUL};
    endfunction

    function bit punct_kind(logic [7:0] c, output kind_t kind);
      kind = KIND_ERROR;
      case (c)
        "(": kind = KIND_LPAREN;
        ")": kind = KIND_RPAREN;
        "+": kind = KIND_PLUS;
        "-": kind = KIND_MINUS;
        "@": kind = KIND_AT;
        "!": kind = KIND_BANG;
        "&": kind = KIND_AMP;
        "|": kind = KIND_PIPE;
        "=": kind = KIND_EQ;
        ";": kind = KIND_SEMI;
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    // Only identifiers of three bytes or fewer can be keywords; shorter
    // prefixes are zero-extended, so a plain compare is enough.
    function kind_t ident_kind();
      if (lexeme_length > 3'd3) return KIND_IDENT;
      case (lexeme_prefix)
        "JGT": return KIND_JGT;
        "JLT": return KIND_JLT;
        "JGE": return KIND_JGE;
        "JLE": return KIND_JLE;
        "JEQ": return KIND_JEQ;
        "JNE": return KIND_JNE;
        "JMP": return KIND_JMP;
        "M":   return KIND_DST_M;
        "D":   return KIND_DST_D;
        "DM":  return KIND_DST_DM;
        "A":   return KIND_DST_A;
        "AM":  return KIND_DST_AM;
        "AD":  return KIND_DST_AD;
        "ADM": return KIND_DST_ADM;
        default: return KIND_IDENT;
      endcase
    endfunction

    function void add_token(kind_t kind, offset_t first, offset_t past);
      ast_out_t tok;
      tok.token_kind  = kind;
      tok.token_start = first;
      tok.token_end   = past;
      tok.run_last    = 1'b0;
      step_tokens.push_back(tok);
    endfunction

    function void close_lexeme(offset_t past);
      if (mode == SCAN_NUMBER) add_token(KIND_NUMBER, lexeme_start, past);
      else if (mode == SCAN_IDENT) add_token(ident_kind(), lexeme_start, past);
      mode = SCAN_IDLE;
    endfunction

    function void note_byte(ast_in_t item);
      logic [7:0] c;
      offset_t    here;
      offset_t    past;
      kind_t      pk;
      bit         classify;
      ast_out_t   tok;
      c        = item.source_byte;
      here     = next_offset;
      past     = (here == '1) ? here : here + 1'b1;
      classify = 1'b1;
      bytes_noted++;
      case (mode)
        SCAN_NUMBER: begin
          if (is_numeral(c)) classify = 1'b0;
          else close_lexeme(here);
        end
        SCAN_IDENT: begin
          if (is_numeral(c) || is_word_char(c)) begin
            if (lexeme_length < 3'd3) lexeme_prefix = {lexeme_prefix[15:0], c};
            if (lexeme_length < 3'd4) lexeme_length = lexeme_length + 1'b1;
            classify = 1'b0;
          end else begin
            close_lexeme(here);
          end
        end
        SCAN_SKIP_LINE: begin
          if (c == CH_NEWLINE) mode = SCAN_IDLE;
          classify = 1'b0;
        end
        default: mode = SCAN_IDLE;
      endcase
      if (classify) begin
        if (is_blank(c)) begin
          // whitespace, including NUL, is dropped
        end else if (c == CH_SLASH) begin
          mode = SCAN_SKIP_LINE;
        end else if (punct_kind(c, pk)) begin
          add_token(pk, here, past);
        end else if (is_numeral(c)) begin
          mode         = SCAN_NUMBER;
          lexeme_start = here;
        end else if (is_word_char(c)) begin
          mode          = SCAN_IDENT;
          lexeme_start  = here;
          lexeme_prefix = {16'h0, c};
          lexeme_length = 3'd1;
        end else begin
          add_token(KIND_ERROR, here, past);
          mode = SCAN_SKIP_LINE;
        end
      end
      next_offset = past;
      if (item.end_of_source) begin
        close_lexeme(past);
        add_token(KIND_EOF, past, past);
        clear_state();
      end
      if (step_tokens.size() > 0) begin
        tok = step_tokens.pop_back();
        tok.run_last = 1'b1;
        step_tokens.push_back(tok);
      end
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
      step_tokens.delete();
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_token(ast_out_t got);
      ast_out_t want;
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("token kind %0d [%0d,%0d) with nothing expected",
                                  got.token_kind, got.token_start, got.token_end));
        return;
      end
      want = expected_tokens.pop_front();
      tokens_checked++;
      if (got.token_kind != want.token_kind)
        report_mismatch($sformatf("token %0d kind %0d, want %0d",
                                  tokens_checked, got.token_kind, want.token_kind));
      if (got.token_start != want.token_start)
        report_mismatch($sformatf("token %0d start %0d, want %0d",
                                  tokens_checked, got.token_start, want.token_start));
      if (got.token_end != want.token_end)
        report_mismatch($sformatf("token %0d end %0d, want %0d",
                                  tokens_checked, got.token_end, want.token_end));
      if (got.run_last != want.run_last)
        report_mismatch($sformatf("token %0d run_last %0b, want %0b",
                                  tokens_checked, got.run_last, want.run_last));
    endtask

    function int pending();
      return expected_tokens.size();
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  ast_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ast_out_t out_data;

  lexer_checker sb = new();

  // Shared knobs between the stimulus and the result sink. The idle rate
  // applies to both channels; the hold request asks the sink for one long
  // stall while bytes keep coming.
  int idle_pct = 35;
  bit hold_request = 1'b0;
  int quiet_cycles = 0;
  int sources_sent = 0;

  ast_in_t source_bytes[$];

  string keyword_names[14] = '{"JGT", "JLT", "JGE", "JLE", "JEQ", "JNE", "JMP",
                               "M", "D", "DM", "A", "AM", "AD", "ADM"};
  string dest_names[7]  = '{"M", "D", "DM", "A", "AM", "AD", "ADM"};
  string jump_names[7]  = '{"JGT", "JLT", "JGE", "JLE", "JEQ", "JNE", "JMP"};
  string comp_names[10] = '{"0", "1", "-1", "D", "!A", "D+1", "D-A", "D&M", "D|A", "M+1"};
  string punct_chars    = "()+-@!&|=;";
  string error_chars    = "#%*,:<>?[]^`{}~'\"\\";
  logic [7:0] blank_bytes[8] = '{" ", 8'h0A, 8'h0D, 8'h09, 8'h08, 8'h0B, 8'h0C, 8'h00};

  always #6 clk = ~clk;

  assembly_source_tokenizer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // ---------------------------------------------------------------------
  // Building source text. Bytes are collected for one source at a time and
  // the final byte of each source carries the end flag.
  // ---------------------------------------------------------------------
  task automatic append_byte(logic [7:0] b);
    ast_in_t item;
    item.source_byte   = b;
    item.end_of_source = 1'b0;
    source_bytes.push_back(item);
  endtask

  task automatic append_text(string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endtask

  task automatic mark_end();
    ast_in_t item;
    item = source_bytes.pop_back();
    item.end_of_source = 1'b1;
    source_bytes.push_back(item);
  endtask

  // A letter, one of the extra identifier characters, or optionally a digit.
  function automatic logic [7:0] random_word_char(bit allow_digit);
    case ($urandom_range(allow_digit ? 4 : 3))
      0, 1:    return 8'("a") + 8'($urandom_range(25));
      2:       return 8'("A") + 8'($urandom_range(25));
      3: begin
        case ($urandom_range(2))
          0:       return "_";
          1:       return ".";
          default: return "$";
        endcase
      end
      default: return 8'("0") + 8'($urandom_range(9));
    endcase
  endfunction

  function automatic logic [7:0] random_line_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    return (b == CH_NEWLINE) ? 8'h20 : b;
  endfunction

  // One random piece of source. Most pieces are well-formed pieces of the
  // language (keywords, names, numbers, whole instructions), the rest are
  // comments, bad characters and raw noise.
  task automatic append_random_fragment();
    string kw;
    int    n;
    case ($urandom_range(10))
      0, 1: append_text(keyword_names[$urandom_range(13)]);
      2: begin
        // Keyword with one more character, or the first two of a jump name.
        kw = keyword_names[$urandom_range(13)];
        if ($urandom_range(1)) begin
          append_text(kw);
          append_byte(random_word_char(1'b1));
        end else begin
          append_text(jump_names[$urandom_range(6)].substr(0, 1));
        end
      end
      3: begin
        n = $urandom_range(1, 7);
        append_byte(random_word_char(1'b0));
        for (int i = 1; i < n; i++) append_byte(random_word_char(1'b1));
      end
      4: begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) append_byte(8'("0") + 8'($urandom_range(9)));
      end
      5: append_byte(punct_chars[$urandom_range(punct_chars.len() - 1)]);
      6: begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) append_byte(blank_bytes[$urandom_range(7)]);
      end
      7: begin
        append_byte(CH_SLASH);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) append_byte(random_line_byte());
        append_byte(CH_NEWLINE);
      end
      8: begin
        if ($urandom_range(1)) append_byte(error_chars[$urandom_range(error_chars.len() - 1)]);
        else append_byte(8'($urandom_range(128, 255)));
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) append_byte(random_line_byte());
        append_byte(CH_NEWLINE);
      end
      9: append_byte(8'($urandom_range(255)));
      default: begin
        // dest=comp, optionally followed by ;jump, ended by a newline
        append_text(dest_names[$urandom_range(6)]);
        append_text("=");
        append_text(comp_names[$urandom_range(9)]);
        if ($urandom_range(1)) begin
          append_text(";");
          append_text(jump_names[$urandom_range(6)]);
        end
        append_byte(CH_NEWLINE);
      end
    endcase
    // Usually a separator keeps the next piece from joining this one.
    if ($urandom_range(9) < 7) begin
      case ($urandom_range(3))
        0:       append_text(" ");
        1:       append_byte(CH_NEWLINE);
        2:       append_text(";");
        default: append_byte(8'h09);
      endcase
    end
  endtask

  // ---------------------------------------------------------------------
  // Driving the input channel. A byte is offered after a random number of
  // idle cycles and held until it is taken; the scoreboard hears of it at
  // the edge of its transfer.
  // ---------------------------------------------------------------------
  task automatic send_byte(ast_in_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(item);
  endtask

  task automatic send_source();
    foreach (source_bytes[i]) send_byte(source_bytes[i]);
    source_bytes.delete();
    sources_sent++;
  endtask

  // The sender goes quiet until every predicted token has come out.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Result sink. It stalls at the shared idle rate, and on request holds
  // out_ready low for a long stretch so that the group queue fills and the
  // block has to drop in_ready. Every token transfer goes to the scoreboard.
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_token(out_data);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Watchdog: a long run of cycles with no transfer on either side means the
  // block has stopped making progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Watchdog expired with %0d tokens outstanding", sb.pending());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence: reset, a directed source, then random sources until the
  // byte budget is spent, then drain and report.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int src;
    int frags;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed source: a jump keyword, a three-letter destination, every
    // punctuation mark, a name with a digit and two of the extra name characters,
    // a comment, a byte above 127 that causes an error and kills its line,
    // a NUL treated as blank, and a final byte that closes a number, gives
    // its own punctuation token and the end-of-file token, three in all.
    append_text("JLT;ADM=D+1 $x9.(@)!&|-/c");
    append_byte(CH_NEWLINE);
    append_byte(8'hFF);
    append_text("q");
    append_byte(CH_NEWLINE);
    append_byte(CH_NUL);
    append_text("7;");
    mark_end();
    send_source();

    // The first six random sources always run so that every phase is seen.
    src = 0;
    while (src < 6 || sb.bytes_noted < TARGET_BYTES) begin
      // Source 3 is long and runs with no idle cycles on either side.
      idle_pct = (src == 3) ? 0 : 35;
      // Source 1 starts while the sink is asked for its long stall.
      if (src == 1) hold_request = 1'b1;
      frags = (src == 3) ? 24 : $urandom_range(1, 12);
      for (int i = 0; i < frags; i++) append_random_fragment();
      mark_end();
      send_source();
      if (src == 5) wait_for_drain();
      src++;
    end
    idle_pct = 35;
    in_valid <= 1'b0;

    // Let every predicted token come out, then watch a few more cycles for
    // anything extra.
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Streamed %0d bytes in %0d sources and compared %0d tokens.",
             sb.bytes_noted, sources_sent, sb.tokens_checked);
    $display("Phases covered a long output stall, a full drain and a stretch with no idling.");
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ast_pkg.sv
rtl/ast_front.sv
rtl/ast_queue.sv
rtl/ast_back.sv
rtl/assembly_source_tokenizer.sv
rtl/ast_checker.sv
verif/assembly_source_tokenizer_tb.sv
